>>> rtl/core/text_line_locator_defines.svh
// Assertion macros shared by the text line locator RTL.
// The macros expect signals named clk and rst_n in the scope where they are used.
`ifndef TEXT_LINE_LOCATOR_DEFINES_SVH
`define TEXT_LINE_LOCATOR_DEFINES_SVH

// This check is active only outside reset.
`define TLL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// This check also holds while reset is applied.
`define TLL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/tll_pkg.sv
// Shared types, codes and sizes for the text line locator.
// This file has no dependencies. The search unit and the top level use it.
package tll_pkg;

  localparam int MAX_LINES     = 1024;
  localparam int POSITION_BITS = 24;
  localparam int IDX_BITS      = $clog2(MAX_LINES);
  localparam int LINE_BITS     = IDX_BITS + 1;

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [IDX_BITS-1:0]      idx_t;
  typedef logic [LINE_BITS-1:0]     line_t;
  typedef logic [1:0]               cmd_t;
  typedef logic [1:0]               status_t;
  typedef logic [7:0]               byte_t;

  // Command codes.
  localparam cmd_t CMD_APPEND = 2'd0;
  localparam cmd_t CMD_LOCATE = 2'd1;
  localparam cmd_t CMD_CLEAR  = 2'd2;

  // Status codes.
  localparam status_t STAT_OK       = 2'd0;
  localparam status_t STAT_RANGE    = 2'd1;
  localparam status_t STAT_OVERFLOW = 2'd2;

  localparam byte_t NEWLINE  = 8'h0A;
  localparam pos_t  POS_MAX  = '1;
  localparam idx_t  LAST_IDX = idx_t'(MAX_LINES - 1);

  // Request from the top level to the search unit.
  typedef struct packed {
    logic start;
    pos_t query;
    idx_t count;
  } srch_req_t;

  // Response from the search unit to the top level.
  typedef struct packed {
    logic done;
    idx_t line_idx;
    pos_t line_base;
  } srch_rsp_t;

endpackage

>>> rtl/core/tll_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// This file has no dependencies.
module tll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

>>> rtl/core/tll_search.sv
// Binary search sequencer over the line start table.
// This file depends on tll_pkg and drives the read port of a tll_ram instance.
module tll_search (
  input  logic               clk,
  input  logic               rst_n,
  input  tll_pkg::srch_req_t req,
  input  tll_pkg::pos_t      rd_data,
  output logic               rd_en,
  output tll_pkg::idx_t      rd_addr,
  output tll_pkg::srch_rsp_t rsp
);
  import tll_pkg::*;

  // Upper midpoint of the range [lo, hi].
  function automatic idx_t mid_of(input idx_t lo, input idx_t hi);
    logic [IDX_BITS:0] span;
    span = {1'b0, hi} - {1'b0, lo} + (IDX_BITS+1)'(1);
    return lo + idx_t'(span >> 1);
  endfunction

  logic busy_r;
  logic done_r;
  idx_t lo_r;
  idx_t hi_r;
  idx_t mid_r;
  pos_t val_r;
  pos_t q_r;

  logic take;
  logic more;
  idx_t lo_nxt;
  idx_t hi_nxt;
  idx_t mid_nxt;
  pos_t val_nxt;
  idx_t start_mid;

  // Narrow the range from the entry that was read in the previous cycle.
  always_comb begin
    take      = (rd_data <= q_r);
    lo_nxt    = take ? mid_r : lo_r;
    hi_nxt    = take ? hi_r : (mid_r - idx_t'(1));
    val_nxt   = take ? rd_data : val_r;
    more      = (lo_nxt < hi_nxt);
    mid_nxt   = mid_of(lo_nxt, hi_nxt);
    start_mid = mid_of('0, req.count);
  end

  // Issue the next table read in the same cycle as the compare.
  assign rd_en   = (req.start && (req.count != '0)) || (busy_r && more);
  assign rd_addr = busy_r ? mid_nxt : start_mid;

  // Search control. Entry zero is never read, so its value is held as a constant zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        q_r    <= req.query;
        lo_r   <= '0;
        hi_r   <= req.count;
        val_r  <= '0;
        mid_r  <= start_mid;
        busy_r <= (req.count != '0);
        done_r <= (req.count == '0);
      end else if (busy_r) begin
        lo_r  <= lo_nxt;
        hi_r  <= hi_nxt;
        val_r <= val_nxt;
        mid_r <= mid_nxt;
        if (!more) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done_r;
  assign rsp.line_idx  = lo_r;
  assign rsp.line_base = val_r;

endmodule

>>> rtl/core/text_line_locator.sv
// Text line locator. After an append or clear transfer the next transfer is taken in the
// following cycle. A locate is accepted, makes one table read per search step (about log2 of
// the line count, at most 10 steps), then passes through the result register to the output
// register, which waits while the previous output has not been taken.
// A synchronous active-low reset empties the table and clears the length and overflow state.
// No clearing pass is needed.
`include "text_line_locator_defines.svh"

module text_line_locator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tll_pkg::cmd_t       in_command,
  input  tll_pkg::byte_t      in_data_byte,
  input  tll_pkg::pos_t       in_query_position,
  output logic                out_valid,
  input  logic                out_ready,
  output tll_pkg::line_t      out_line_no,
  output tll_pkg::pos_t       out_char_offset,
  output tll_pkg::status_t    out_status
);
  import tll_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_HOLD   = 2'd2;

  logic [1:0] state_r, state_nxt;
  pos_t       text_len_r, text_len_nxt;
  idx_t       line_count_r, line_count_nxt;
  logic       overflow_r, overflow_nxt;
  logic       out_valid_r, out_valid_nxt;

  pos_t    q_r;
  line_t   res_line_r;
  pos_t    res_col_r;
  status_t res_stat_r;
  line_t   out_line_r;
  pos_t    out_col_r;
  status_t out_stat_r;

  logic      in_fire;
  logic      out_load;
  logic      in_range;
  logic      ram_we;
  idx_t      ram_waddr;
  pos_t      ram_wdata;
  logic      ram_re;
  idx_t      ram_raddr;
  pos_t      ram_rdata;
  srch_req_t srch_req;
  srch_rsp_t srch_rsp;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign in_range = (in_query_position < text_len_r);
  assign out_load = (state_r == ST_HOLD) && (!out_valid_r || out_ready);

  // Append a line start after each newline while the table has room.
  assign ram_we    = in_fire && (in_command == CMD_APPEND) && (text_len_r != POS_MAX) &&
                     (in_data_byte == NEWLINE) && (line_count_r != LAST_IDX);
  assign ram_waddr = line_count_r + idx_t'(1);
  assign ram_wdata = text_len_r + pos_t'(1);

  // Start a search only for an offset inside the scanned text.
  assign srch_req.start = in_fire && (in_command == CMD_LOCATE) && in_range;
  assign srch_req.query = in_query_position;
  assign srch_req.count = line_count_r;

  tll_ram #(
    .WIDTH(POSITION_BITS),
    .DEPTH(MAX_LINES)
  ) u_line_start (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  tll_search u_search (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (srch_req),
    .rd_data(ram_rdata),
    .rd_en  (ram_re),
    .rd_addr(ram_raddr),
    .rsp    (srch_rsp)
  );

  // Control state: scan counters, sequencing and the output valid flag.
  always_comb begin
    state_nxt      = state_r;
    text_len_nxt   = text_len_r;
    line_count_nxt = line_count_r;
    overflow_nxt   = overflow_r;
    out_valid_nxt  = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_command)
            CMD_APPEND: begin
              if (text_len_r != POS_MAX) begin
                text_len_nxt = text_len_r + pos_t'(1);
                if (in_data_byte == NEWLINE) begin
                  if (line_count_r != LAST_IDX) begin
                    line_count_nxt = line_count_r + idx_t'(1);
                  end else begin
                    overflow_nxt = 1'b1;
                  end
                end
              end
            end
            CMD_LOCATE: begin
              state_nxt = in_range ? ST_SEARCH : ST_HOLD;
            end
            CMD_CLEAR: begin
              text_len_nxt   = '0;
              line_count_nxt = '0;
              overflow_nxt   = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SEARCH: begin
        if (srch_rsp.done) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      text_len_r   <= '0;
      line_count_r <= '0;
      overflow_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      text_len_r   <= text_len_nxt;
      line_count_r <= line_count_nxt;
      overflow_r   <= overflow_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Result payload: an out-of-range locate is settled at accept, and a search at its end.
  always_ff @(posedge clk) begin
    if (in_fire && (in_command == CMD_LOCATE)) begin
      q_r        <= in_query_position;
      res_line_r <= '0;
      res_col_r  <= '0;
      res_stat_r <= STAT_RANGE;
    end
    if ((state_r == ST_SEARCH) && srch_rsp.done) begin
      res_line_r <= {1'b0, srch_rsp.line_idx} + line_t'(1);
      res_col_r  <= q_r - srch_rsp.line_base + pos_t'(1);
      res_stat_r <= overflow_r ? STAT_OVERFLOW : STAT_OK;
    end
    if (out_load) begin
      out_line_r <= res_line_r;
      out_col_r  <= res_col_r;
      out_stat_r <= res_stat_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_line_no     = out_line_r;
  assign out_char_offset = out_col_r;
  assign out_status      = out_stat_r;

  // Checks on the scan state and the search sequencing.
  `TLL_ASSERT(a_ovf_full, overflow_r |-> (line_count_r == LAST_IDX), "overflow with table not full")
  `TLL_ASSERT(a_done_in_search, srch_rsp.done |-> (state_r == ST_SEARCH), "done outside search")
  `TLL_ASSERT(a_line_set, out_valid && out_status != STAT_RANGE |-> out_line_no != '0, "zero line")
  `TLL_ASSERT_ALWAYS(a_no_write_busy, (state_r != ST_IDLE) |-> !ram_we, "table write during locate")

endmodule
